@@ rtl/core/bpl2_pkg.sv @@
// shared constants, types and controller codes for the l2 bin packing bound block
package bpl2_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_ITEMS);
  localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W       = WEIGHT_BITS + ADDR_W;
  localparam int PROD_W      = CNT_W + WEIGHT_BITS;
  localparam int TOT_W       = PROD_W + 1;
  localparam int QCNT_W      = $clog2(PROD_W + 1);
  localparam int BOUND_W     = 7;
  localparam int BOUND_MAX   = 127;
  localparam int CAP_RESET   = 100;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUTER_RD,
    S_A_LOAD,
    S_INNER,
    S_DRAIN,
    S_MUL,
    S_PREP,
    S_DIV,
    S_UPD,
    S_NEXT,
    S_FIN,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic store;
    logic i_clr;
    logic i_inc;
    logic outer_rd;
    logic a_load;
    logic j_clr;
    logic inner_rd;
    logic mul;
    logic div_start;
    logic upd;
    logic fin;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic j_last;
    logic a_small;
    logic div_busy;
    logic out_busy;
  } dp_stat_t;

endpackage

@@ rtl/core/bpl2_intf.sv @@
// valid/ready channel interfaces for item words and bound words
interface bpl2_item_if import bpl2_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] item_weight;
  logic                   last_item;

  modport source (output valid, item_weight, last_item, input ready);
  modport sink   (input valid, item_weight, last_item, output ready);
endinterface

interface bpl2_bound_if import bpl2_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BOUND_W-1:0] lower_bound;
  logic               overflow;

  modport source (output valid, lower_bound, overflow, input ready);
  modport sink   (input valid, lower_bound, overflow, output ready);
endinterface

@@ rtl/core/bpl2_div.sv @@
// restoring divider, one quotient bit per cycle
module bpl2_div import bpl2_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PROD_W-1:0]      num,
  input  logic [WEIGHT_BITS-1:0] den,
  output logic                   busy,
  output logic [PROD_W-1:0]      quot
);

  logic [WEIGHT_BITS-1:0] rem;
  logic [PROD_W-1:0]      q;
  logic [QCNT_W-1:0]      cnt;
  logic [WEIGHT_BITS:0]   shifted;
  logic                   ge;

  assign shifted = {rem, q[PROD_W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= QCNT_W'(PROD_W);
      rem  <= '0;
      q    <= num;
    end else if (busy) begin
      rem  <= ge ? WEIGHT_BITS'(shifted - {1'b0, den}) : shifted[WEIGHT_BITS-1:0];
      q    <= {q[PROD_W-2:0], ge};
      cnt  <= cnt - QCNT_W'(1);
      if (cnt == QCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/core/bpl2_dp.sv @@
// datapath: weight store, index counters, class sums, slack math and result register
module bpl2_dp import bpl2_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [WEIGHT_BITS-1:0] cfg_wr_data,
  input  logic [WEIGHT_BITS-1:0] in_weight,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BOUND_W-1:0]     out_bound,
  output logic                   out_ovf
);

  logic [WEIGHT_BITS-1:0] cap;
  logic [CNT_W-1:0]       count;
  logic                   ovf;
  logic [WEIGHT_BITS-1:0] mem [MAX_ITEMS];
  logic [WEIGHT_BITS-1:0] rdata;
  logic                   rd_vld;
  logic [ADDR_W-1:0]      i_idx;
  logic [ADDR_W-1:0]      j_idx;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WEIGHT_BITS-1:0] a_reg;
  logic [CNT_W-1:0]       n1;
  logic [CNT_W-1:0]       n2;
  logic [SUM_W-1:0]       large_sum;
  logic [SUM_W-1:0]       small_sum;
  logic [PROD_W-1:0]      prod;
  logic                   use_q;
  logic                   any_seen;
  logic [BOUND_W-1:0]     best;

  logic                   full;
  logic [WEIGHT_BITS-1:0] half;
  logic [WEIGHT_BITS-1:0] top;
  logic [PROD_W-1:0]      slack;
  logic [PROD_W-1:0]      small_ext;
  logic                   need_q;
  logic [PROD_W-1:0]      div_num;
  logic                   div_busy;
  logic [PROD_W-1:0]      quot;
  logic [TOT_W-1:0]       tot;
  logic [BOUND_W-1:0]     b_sat;
  logic [BOUND_W-1:0]     cnt_sat;

  assign full      = count >= CNT_W'(MAX_ITEMS);
  assign half      = cap >> 1;
  assign top       = cap - a_reg;
  assign rd_addr   = cmd.inner_rd ? j_idx : i_idx;
  assign slack     = prod - PROD_W'(large_sum);
  assign small_ext = PROD_W'(small_sum);
  assign need_q    = (cap != '0) && (small_ext > slack);
  assign div_num   = need_q ? (small_ext - slack + PROD_W'(cap) - PROD_W'(1)) : '0;
  assign tot       = TOT_W'(n1) + TOT_W'(n2) + (use_q ? TOT_W'(quot) : TOT_W'(0));
  assign b_sat     = (tot > TOT_W'(BOUND_MAX)) ? BOUND_W'(BOUND_MAX) : tot[BOUND_W-1:0];
  assign cnt_sat   = (TOT_W'(count) > TOT_W'(BOUND_MAX)) ? BOUND_W'(BOUND_MAX)
                                                          : BOUND_W'(count);

  assign stat.i_last   = CNT_W'(i_idx) == count - CNT_W'(1);
  assign stat.j_last   = CNT_W'(j_idx) == count - CNT_W'(1);
  assign stat.a_small  = rdata <= half;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid && !out_ready;

  bpl2_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cap),
    .busy  (div_busy),
    .quot  (quot)
  );

  // store and read port
  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem[count[ADDR_W-1:0]] <= in_weight;
    end
    if (cmd.outer_rd || cmd.inner_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= WEIGHT_BITS'(CAP_RESET);
      count     <= '0;
      ovf       <= 1'b0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.inner_rd;
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      if (cmd.store) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        count     <= '0;
        ovf       <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.i_clr) begin
      i_idx    <= '0;
      any_seen <= 1'b0;
    end else if (cmd.i_inc) begin
      i_idx <= i_idx + ADDR_W'(1);
    end
    if (cmd.j_clr) begin
      j_idx <= '0;
    end else if (cmd.inner_rd) begin
      j_idx <= j_idx + ADDR_W'(1);
    end
    if (cmd.a_load) begin
      a_reg <= rdata;
    end
    // sort each stored weight into its class for the current candidate
    if (cmd.j_clr) begin
      n1        <= '0;
      n2        <= '0;
      large_sum <= '0;
      small_sum <= '0;
    end else if (rd_vld) begin
      if (rdata > top) begin
        n1 <= n1 + CNT_W'(1);
      end else if (rdata > half) begin
        n2        <= n2 + CNT_W'(1);
        large_sum <= large_sum + SUM_W'(rdata);
      end else if (rdata >= a_reg) begin
        small_sum <= small_sum + SUM_W'(rdata);
      end
    end
    if (cmd.mul) begin
      prod <= PROD_W'(n2) * PROD_W'(cap);
    end
    if (cmd.div_start) begin
      use_q <= need_q;
    end
    if (cmd.upd) begin
      if (!any_seen || b_sat > best) begin
        best <= b_sat;
      end
      any_seen <= 1'b1;
    end
    if (cmd.fin && !any_seen) begin
      best <= cnt_sat;
    end
    if (cmd.emit) begin
      out_bound <= best;
      out_ovf   <= ovf;
    end
  end

endmodule

@@ rtl/core/bpl2_ctrl.sv @@
// controller: sequences the outer candidate loop, the inner scan and the divide
module bpl2_ctrl import bpl2_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store = 1'b1;
          if (in_last) begin
            cmd.i_clr  = 1'b1;
            state_next = S_OUTER_RD;
          end
        end
      end
      S_OUTER_RD: begin
        cmd.outer_rd = 1'b1;
        state_next   = S_A_LOAD;
      end
      S_A_LOAD: begin
        cmd.a_load = 1'b1;
        if (stat.a_small) begin
          cmd.j_clr  = 1'b1;
          state_next = S_INNER;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_INNER: begin
        cmd.inner_rd = 1'b1;
        if (stat.j_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_MUL;
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.i_last) begin
          state_next = S_FIN;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = S_OUTER_RD;
        end
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/bin_packing_l2_lower_bound_top.sv @@
// top level of the l2 bin packing lower bound block
// usage:
//   items: one word per item (item_weight, last_item). every word, the
//   closing one too, is written into a 64-entry weight store; words past the
//   64th are dropped and flagged in the overflow bit of the result.
//   a word with last_item set closes the set and starts the bound search.
//   bounds: one word per set (lower_bound, overflow), held in an output
//   register until the receiver takes it; items keep flowing meanwhile.
//   search for a set of n stored weights: the outer pass reads, loads and
//   steps past every weight, and each candidate at most half the capacity
//   adds an inner scan of the n weights, a drain, a multiply, a 23-step
//   serial divide with its start and an update; then the fin and emit
//   states load the result. the store's single read port and the divider
//   set the search time; no items are taken during the search.
//   a stalled receiver leaves its bound in the output register; the next
//   finished bound waits in the datapath and blocks new items until then.
//   cfg_wr_en/cfg_wr_data write the bin capacity; write it only while idle.
//   reset: synchronous, clears the store fill count, the overflow flag and
//   the output valid, and sets the capacity to 100.
module bin_packing_l2_lower_bound_top import bpl2_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [WEIGHT_BITS-1:0] cfg_wr_data,
  bpl2_item_if.sink              items,
  bpl2_bound_if.source           bounds
);

  // command and status between controller and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bpl2_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_last  (items.last_item),
    .in_ready (items.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpl2_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_weight   (items.item_weight),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (bounds.valid),
    .out_ready   (bounds.ready),
    .out_bound   (bounds.lower_bound),
    .out_ovf     (bounds.overflow)
  );

endmodule

@@ tb/bin_packing_l2_lower_bound_top_tb.sv @@
// testbench for the l2 bin packing lower bound block: directed and random item sets checked against a predictor

class l2_bound_tracker;

  typedef struct packed {
    logic [bpl2_pkg::BOUND_W-1:0] lower_bound;
    logic                         overflow;
  } bound_word_t;

  bound_word_t                        bounds_due[$];
  logic [bpl2_pkg::WEIGHT_BITS-1:0]   weights[bpl2_pkg::MAX_ITEMS];
  logic [bpl2_pkg::WEIGHT_BITS-1:0]   capacity;
  int unsigned                        fill;
  bit                                 dropped;
  int unsigned                        errors;

  function new();
    capacity = bpl2_pkg::CAP_RESET[bpl2_pkg::WEIGHT_BITS-1:0];
    fill     = 0;
    dropped  = 0;
    errors   = 0;
  endfunction

  function void set_capacity(logic [bpl2_pkg::WEIGHT_BITS-1:0] cap);
    capacity = cap;
  endfunction

  // martello-toth l2 over the stored weights of the current set
  function logic [bpl2_pkg::BOUND_W-1:0] l2_bound();
    longint unsigned cap, half, top, a, w, n1, n2, big, little, slack, total, best;
    bit any;
    cap  = capacity;
    half = cap / 2;
    best = 0;
    any  = 0;
    for (int i = 0; i < fill; i++) begin
      a = weights[i];
      if (a <= half) begin
        top    = cap - a;
        n1     = 0;
        n2     = 0;
        big    = 0;
        little = 0;
        for (int j = 0; j < fill; j++) begin
          w = weights[j];
          if (w > top) begin
            n1++;
          end else if (w > half) begin
            n2++;
            big += w;
          end else if (w >= a) begin
            little += w;
          end
        end
        total = n1 + n2;
        slack = n2 * cap - big;
        if (cap != 0 && little > slack) total += (little - slack + cap - 1) / cap;
        if (!any || total > best) best = total;
        any = 1;
      end
    end
    if (!any) best = fill;
    if (best > bpl2_pkg::BOUND_MAX) best = bpl2_pkg::BOUND_MAX;
    return best[bpl2_pkg::BOUND_W-1:0];
  endfunction

  function void note_item(logic [bpl2_pkg::WEIGHT_BITS-1:0] w, logic last);
    bound_word_t word;
    if (fill < bpl2_pkg::MAX_ITEMS) begin
      weights[fill] = w;
      fill++;
    end else begin
      dropped = 1;
    end
    if (last) begin
      word.lower_bound = l2_bound();
      word.overflow    = dropped;
      bounds_due.push_back(word);
      fill    = 0;
      dropped = 0;
    end
  endfunction

  task report_mismatch(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_bound(logic [bpl2_pkg::BOUND_W-1:0] lb, logic ovf);
    bound_word_t want;
    if (bounds_due.size() == 0) begin
      report_mismatch($sformatf("bound word %0d/%0d with none due", lb, ovf));
    end else begin
      want = bounds_due.pop_front();
      if (lb !== want.lower_bound)
        report_mismatch($sformatf("lower_bound got %0d want %0d", lb, want.lower_bound));
      if (ovf !== want.overflow)
        report_mismatch($sformatf("overflow got %0d want %0d", ovf, want.overflow));
    end
  endtask

endclass

module bin_packing_l2_lower_bound_top_tb;
  import bpl2_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [WEIGHT_BITS-1:0] cfg_wr_data;

  bpl2_item_if  items_ch ();
  bpl2_bound_if bounds_ch ();

  bin_packing_l2_lower_bound_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .items       (items_ch),
    .bounds      (bounds_ch)
  );

  l2_bound_tracker tracker = new();

  // words left in the current sender burst
  int burst_left = 0;
  int items_sent = 0;

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // capacity write, only called while the block is idle
  task write_capacity(input logic [WEIGHT_BITS-1:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_capacity(cap);
  endtask

  // one item word; bursts of random length with random gaps in between
  task send_item(input logic [WEIGHT_BITS-1:0] w, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      // a zero gap keeps valid high, so no low/high pair lands in one step
      if (gap != 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    items_ch.valid       <= 1'b1;
    items_ch.item_weight <= w;
    items_ch.last_item   <= last;
    // pre-edge values seen here: accepted when ready was high with our valid
    do @(posedge clk); while (items_ch.ready !== 1'b1);
    tracker.note_item(w, last);
    burst_left--;
    items_sent++;
  endtask

  // weights placed around the interesting points of the current capacity
  function automatic logic [WEIGHT_BITS-1:0] pick_weight(logic [WEIGHT_BITS-1:0] cap);
    int unsigned c, half, r;
    c    = cap;
    half = c / 2;
    case ($urandom_range(0, 9))
      0:       r = 0;
      1:       r = half;
      2:       r = half + 1;
      3:       r = (c > 3) ? c - $urandom_range(0, 3) : c;
      4:       r = $urandom_range(0, 65535);      // may exceed capacity
      5, 6:    r = $urandom_range(0, half);
      7, 8:    r = $urandom_range(half, c);
      default: r = $urandom_range(0, c);
    endcase
    return WEIGHT_BITS'(r);
  endfunction

  // one set of random weights, closed by a last word
  task send_set(input int n);
    for (int i = 0; i < n; i++)
      send_item(pick_weight(tracker.capacity), i == n - 1);
  endtask

  // sender goes quiet, all bounds come back, then the block settles
  task drain;
    items_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.bounds_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // a phase: new capacity, then sets until about n items have gone in
  task run_phase(input logic [WEIGHT_BITS-1:0] cap, input int n);
    int start;
    write_capacity(cap);
    start = items_sent;
    while (items_sent - start < n) begin
      // mostly small sets keep the n squared search short
      if ($urandom_range(0, 19) == 0) send_set($urandom_range(40, 66));
      else send_set($urandom_range(1, 12));
    end
    drain();
  endtask

  // bound checker, sampling pre-edge handshake values
  always @(posedge clk) begin
    if (!rst && bounds_ch.valid === 1'b1 && bounds_ch.ready === 1'b1)
      tracker.check_bound(bounds_ch.lower_bound, bounds_ch.overflow);
  end

  // receiver stall pattern: runs of always ready, coin flip, sparse and full stall
  initial begin
    int mode, span;
    bounds_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 150);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       bounds_ch.ready <= 1'b1;
          1:       bounds_ch.ready <= $urandom_range(0, 1);
          2:       bounds_ch.ready <= ($urandom_range(0, 7) == 0);
          default: bounds_ch.ready <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_wr_data          <= '0;
    items_ch.valid       <= 1'b0;
    items_ch.item_weight <= '0;
    items_ch.last_item   <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed sets at the reset capacity
    write_capacity(16'd100);
    // all zero weights give bound 0
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b0);
    send_item(16'd0, 1'b1);
    // weights above capacity land in j1
    send_item(16'd150, 1'b0);
    send_item(16'd30, 1'b0);
    send_item(16'hffff, 1'b1);
    // nothing at most half the capacity: bound is the count
    send_item(16'd60, 1'b0);
    send_item(16'd70, 1'b0);
    send_item(16'd80, 1'b1);
    // single item set
    send_item(16'd50, 1'b1);
    // weights around half and full capacity
    send_item(16'd1, 1'b0);
    send_item(16'd49, 1'b0);
    send_item(16'd50, 1'b0);
    send_item(16'd51, 1'b0);
    send_item(16'd99, 1'b0);
    send_item(16'd100, 1'b1);
    drain();

    // smallest nonzero capacity
    write_capacity(16'd1);
    send_item(16'd0, 1'b0);
    send_item(16'd1, 1'b0);
    send_item(16'd1, 1'b1);
    drain();

    // capacity zero: no quotient is added, nonzero weights count one bin each
    write_capacity(16'd0);
    send_item(16'd0, 1'b0);
    send_item(16'd5, 1'b0);
    send_item(16'd0, 1'b1);
    drain();

    // store full: 66 words, the last two dropped, the closing one among them
    write_capacity(16'hffff);
    send_set(66);
    drain();

    // random phases over several capacities
    run_phase(16'hffff, 40);
    run_phase(16'd100, 40);
    run_phase(16'd2, 40);
    run_phase(16'd1, 30);
    run_phase(WEIGHT_BITS'($urandom_range(3, 1000)), 40);
    run_phase(WEIGHT_BITS'($urandom_range(1, 65535)), 40);
    run_phase(16'd0, 20);
    run_phase(WEIGHT_BITS'($urandom_range(10, 300)), 40);

    if (tracker.errors == 0 && tracker.bounds_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
